// ===== hw/rtl/mmsu_pkg.sv =====
// shared types, codes and constants for the metropolis momentum state update block
// no dependencies; imported by metropolis_momentum_state_update
package mmsu_pkg;

  localparam int MAX_PARTICLES_DEF = 256;
  localparam int INDEX_BITS_DEF    = 8;
  localparam int DIMENSIONS_DEF    = 3;

  localparam logic [1:0]  MODE_BOSON   = 2'd1;
  localparam logic [1:0]  MODE_FERMION = 2'd2;
  localparam logic        ACT_LOAD     = 1'b0;
  localparam logic        MOVE_STEP    = 1'b1;

  localparam logic [47:0] ENERGY_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam int          EXP_X_BITS   = 21;
  localparam logic [31:0] EXP_Q_LIMIT  = 32'd17;

  localparam logic [1:0]  MODE_RESET   = 2'd0;
  localparam logic [8:0]  COUNT_RESET  = 9'd1;
  localparam logic [31:0] WEIGHT_RESET = 32'd65536;
  localparam logic [23:0] BETA_RESET   = 24'd65536;

  typedef enum logic [2:0] {
    CFG_MODE,
    CFG_COUNT,
    CFG_WEIGHT_X,
    CFG_WEIGHT_Y,
    CFG_WEIGHT_Z,
    CFG_BETA
  } mmsu_cfg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRAP,
    S_LOAD,
    S_RD_CUR,
    S_CUR,
    S_PROPOSE,
    S_OCC_RD,
    S_OCC_CMP,
    S_EN_SQ,
    S_EN_MUL,
    S_EN_END,
    S_DIFF,
    S_X1,
    S_X2,
    S_X3,
    S_EXP1,
    S_EXP2,
    S_EXP3,
    S_CMP1,
    S_CMP2,
    S_CMP3,
    S_COMMIT,
    S_SCAN_GO,
    S_SCAN_RD,
    S_SCAN_LAT,
    S_FIN
  } mmsu_state_t;

  typedef enum logic [1:0] {
    J_NEW,
    J_OLD,
    J_SCAN
  } mmsu_job_t;

  // 2^(-i/16) in q1.16
  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/metropolis_momentum_state_update.sv =====
// metropolis step on a particle store; boson and fermion modes add an occupancy scan of the
// particles in use before the energy step
// one word at a time, next word taken the cycle after the result registers
// a load word writes its slot and rescans the store; all products share one 32x32 multiplier
// reset: sequencer idle, configuration registers at their reset values, total energy zero
// the particle store is not cleared and holds garbage until loaded
module metropolis_momentum_state_update #(
  parameter int MAX_PARTICLES = mmsu_pkg::MAX_PARTICLES_DEF,
  parameter int INDEX_BITS    = mmsu_pkg::INDEX_BITS_DEF,
  parameter int DIMENSIONS    = mmsu_pkg::DIMENSIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [7:0]        in_particle_index,
  input  logic signed [7:0] in_load_x,
  input  logic signed [7:0] in_load_y,
  input  logic signed [7:0] in_load_z,
  input  logic              in_move_kind,
  input  logic              in_step_up,
  input  logic [1:0]        in_move_axis,
  input  logic [15:0]       in_accept_random,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic              out_out_of_range,
  output logic signed [7:0] out_result_x,
  output logic signed [7:0] out_result_y,
  output logic signed [7:0] out_result_z,
  output logic [47:0]       out_total_energy,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import mmsu_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int IB = INDEX_BITS;
  localparam int DW = 3 * IB;

  typedef logic [2:0][IB-1:0] vec_t;

  mmsu_state_t state_r, state_nxt;
  mmsu_job_t   job_r;

  logic [1:0]       mode_r;
  logic [8:0]       count_r;
  logic [2:0][31:0] weight_r;
  logic [23:0]      beta_r;

  logic        act_r, kind_r, up_r;
  logic [7:0]  slot_r;
  logic [1:0]  axis_r;
  logic [15:0] rnd_r;
  vec_t        load_r, cur_r, nw_r, vec_r;

  logic [1:0]    ax_r;
  logic [47:0]   eacc_r;
  logic [63:0]   prod_r;
  logic [CW-1:0] p_r, nn_r, no_r, b_r;
  logic [CW:0]   a_r;
  logic          blocked_r;
  logic [47:0]   en_new_r, en_old_r, mag_r, tot_r;
  logic          neg_r;
  logic [55:0]   xhi_r;
  logic [56:0]   x_r;
  logic [3:0]    i_r;
  logic [4:0]    q_r;
  logic [16:0]   e_r;
  logic [31:0]   rb_r;
  logic          acc_r, oor_r;

  logic [DW-1:0] store_mem [MAX_PARTICLES];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [DW-1:0] wr_data;

  logic              out_valid_r, out_accepted_r, out_oor_r;
  logic signed [7:0] out_x_r, out_y_r, out_z_r;
  logic [47:0]       energy_total_r;

  logic [CW-1:0] n_used;
  logic          wrap_more, axis_ok, v_oor, occ_done, scan_done, fin_go, x_big, q_big, ok;
  logic [1:0]    axis_sel;
  logic [IB-1:0] cur_ax, comp, absn;
  logic [IB:0]   ext, v;
  vec_t          nw_prop, rd_vec;
  logic          same_new, same_cur;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   sum64;
  logic [47:0]   esat, tot_sat;
  logic [48:0]   tsum;
  logic [16:0]   m_val;
  logic [3:0]    i_sel;
  logic          last_ax;

  // ---------------- combinational decisions ----------------
  always_comb begin
    n_used    = (32'(count_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(count_r);
    wrap_more = 32'(slot_r) >= MAX_PARTICLES;
    axis_ok   = 32'(axis_r) < DIMENSIONS;
    axis_sel  = axis_ok ? axis_r : 2'd0;
    cur_ax    = cur_r[axis_sel];
    ext       = {cur_ax[IB-1], cur_ax};
    if (kind_r == MOVE_STEP) begin
      v = up_r ? (ext + (IB+1)'(1)) : (ext - (IB+1)'(1));
    end else begin
      v = (IB+1)'(0) - ext;
    end
    v_oor   = v[IB] != v[IB-1];
    nw_prop = cur_r;
    nw_prop[axis_sel] = v[IB-1:0];

    rd_vec   = vec_t'(rd_data_r);
    same_new = 1'b1;
    same_cur = 1'b1;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (rd_vec[d] != nw_r[d]) same_new = 1'b0;
      if (rd_vec[d] != cur_r[d]) same_cur = 1'b0;
    end

    occ_done  = p_r >= n_used;
    scan_done = p_r >= n_used;
    fin_go    = !out_valid_r || !out_stall;
    last_ax   = ax_r == 2'(DIMENSIONS - 1);

    comp  = vec_r[ax_r];
    absn  = comp[IB-1] ? (IB'(0) - comp) : comp;
    sum64 = 64'(eacc_r) + prod_r;
    esat  = (sum64 > 64'(ENERGY_MAX)) ? ENERGY_MAX : sum64[47:0];
    tsum  = {1'b0, tot_r} + {1'b0, esat};
    tot_sat = tsum[48] ? ENERGY_MAX : tsum[47:0];

    x_big = x_r >= 57'(1) << EXP_X_BITS;
    q_big = prod_r[63:32] >= EXP_Q_LIMIT;
    i_sel = prod_r[31:28];
    m_val = pow2_tab({1'b0, i_r}) - 17'(prod_r[28:12]);
    ok    = neg_r ? (64'({a_r, 32'b0}) > prod_r) : (prod_r > 64'(rb_r));

    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_EN_SQ: begin
        mul_a = 32'(absn);
        mul_b = 32'(absn);
      end
      S_EN_MUL: begin
        mul_a = weight_r[ax_r];
        mul_b = prod_r[31:0];
      end
      S_X1: begin
        mul_a = 32'(beta_r);
        mul_b = 32'(mag_r[47:24]);
      end
      S_X2: begin
        mul_a = 32'(beta_r);
        mul_b = 32'(mag_r[23:0]);
      end
      S_EXP1: begin
        mul_a = 32'(x_r[EXP_X_BITS-1:0]);
        mul_b = 32'(LOG2E_Q16);
      end
      S_EXP2: begin
        mul_a = 32'(pow2_tab({1'b0, i_sel}) - pow2_tab({1'b0, i_sel} + 5'd1));
        mul_b = 32'(prod_r[27:16]);
      end
      S_CMP1: begin
        mul_a = 32'(rnd_r);
        mul_b = 32'(b_r);
      end
      S_CMP2: begin
        if (neg_r) begin
          mul_a = prod_r[31:0];
          mul_b = 32'(e_r);
        end else begin
          mul_a = 32'(e_r);
          mul_b = 32'(a_r);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    wr_en   = (state_r == S_LOAD) || (state_r == S_COMMIT);
    wr_data = (state_r == S_LOAD) ? DW'(load_r) : DW'(nw_r);
    unique case (state_r)
      S_OCC_RD, S_SCAN_RD: rd_addr = AW'(p_r);
      default:             rd_addr = AW'(slot_r);
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    in_stall  = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_WRAP;
      S_WRAP: begin
        if (!wrap_more) state_nxt = (act_r == ACT_LOAD) ? S_LOAD : S_RD_CUR;
      end
      S_LOAD:    state_nxt = S_SCAN_GO;
      S_RD_CUR:  state_nxt = S_CUR;
      S_CUR:     state_nxt = S_PROPOSE;
      S_PROPOSE: begin
        if (!axis_ok || v_oor) state_nxt = S_SCAN_GO;
        else if (mode_r == MODE_BOSON || mode_r == MODE_FERMION) state_nxt = S_OCC_RD;
        else state_nxt = S_EN_SQ;
      end
      S_OCC_RD: begin
        if (!occ_done) state_nxt = S_OCC_CMP;
        else if (mode_r == MODE_FERMION && blocked_r) state_nxt = S_SCAN_GO;
        else state_nxt = S_EN_SQ;
      end
      S_OCC_CMP: state_nxt = S_OCC_RD;
      S_EN_SQ:   state_nxt = S_EN_MUL;
      S_EN_MUL:  state_nxt = last_ax ? S_EN_END : S_EN_SQ;
      S_EN_END: begin
        unique case (job_r)
          J_NEW:   state_nxt = S_EN_SQ;
          J_OLD:   state_nxt = S_DIFF;
          default: state_nxt = S_SCAN_RD;
        endcase
      end
      S_DIFF:    state_nxt = S_X1;
      S_X1:      state_nxt = S_X2;
      S_X2:      state_nxt = S_X3;
      S_X3:      state_nxt = S_EXP1;
      S_EXP1:    state_nxt = x_big ? S_CMP1 : S_EXP2;
      S_EXP2:    state_nxt = q_big ? S_CMP1 : S_EXP3;
      S_EXP3:    state_nxt = S_CMP1;
      S_CMP1:    state_nxt = S_CMP2;
      S_CMP2:    state_nxt = S_CMP3;
      S_CMP3:    state_nxt = ok ? S_COMMIT : S_SCAN_GO;
      S_COMMIT:  state_nxt = S_SCAN_GO;
      S_SCAN_GO: state_nxt = S_SCAN_RD;
      S_SCAN_RD: state_nxt = scan_done ? S_FIN : S_SCAN_LAT;
      S_SCAN_LAT: state_nxt = S_EN_SQ;
      S_FIN:     if (fin_go) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RESET;
      count_r  <= COUNT_RESET;
      weight_r <= {3{WEIGHT_RESET}};
      beta_r   <= BETA_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MODE:     mode_r      <= cfg_data[1:0];
        CFG_COUNT:    count_r     <= cfg_data[8:0];
        CFG_WEIGHT_X: weight_r[0] <= cfg_data;
        CFG_WEIGHT_Y: weight_r[1] <= cfg_data;
        CFG_WEIGHT_Z: weight_r[2] <= cfg_data;
        CFG_BETA:     beta_r      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // ---------------- particle store ----------------
  always_ff @(posedge clk) begin
    if (wr_en) store_mem[AW'(slot_r)] <= wr_data;
    rd_data_r <= store_mem[rd_addr];
  end

  // ---------------- shared multiplier ----------------
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_r     <= in_action;
          slot_r    <= in_particle_index;
          load_r[0] <= IB'(in_load_x);
          load_r[1] <= IB'(in_load_y);
          load_r[2] <= IB'(in_load_z);
          kind_r    <= in_move_kind;
          up_r      <= in_step_up;
          axis_r    <= in_move_axis;
          rnd_r     <= in_accept_random;
          acc_r     <= 1'b0;
          oor_r     <= 1'b0;
        end
      end
      S_WRAP: if (wrap_more) slot_r <= slot_r - 8'(MAX_PARTICLES);
      S_LOAD: cur_r <= load_r;
      S_CUR:  cur_r <= rd_vec;
      S_PROPOSE: begin
        if (axis_ok && v_oor) oor_r <= 1'b1;
        nw_r      <= nw_prop;
        vec_r     <= nw_prop;
        p_r       <= '0;
        nn_r      <= '0;
        no_r      <= '0;
        blocked_r <= 1'b0;
        a_r       <= (CW+1)'(1);
        b_r       <= CW'(1);
        ax_r      <= '0;
        eacc_r    <= '0;
        job_r     <= J_NEW;
      end
      S_OCC_RD: begin
        if (occ_done) begin
          if (mode_r == MODE_BOSON) begin
            a_r <= {1'b0, nn_r} + (CW+1)'(1);
            b_r <= no_r;
          end
          vec_r  <= nw_r;
          ax_r   <= '0;
          eacc_r <= '0;
          job_r  <= J_NEW;
        end
      end
      S_OCC_CMP: begin
        if (same_new && (32'(p_r) != 32'(slot_r))) blocked_r <= 1'b1;
        if (same_new) nn_r <= nn_r + CW'(1);
        if (same_cur) no_r <= no_r + CW'(1);
        p_r <= p_r + CW'(1);
      end
      S_EN_SQ:  if (ax_r != 2'd0) eacc_r <= esat;
      S_EN_MUL: if (!last_ax) ax_r <= ax_r + 2'd1;
      S_EN_END: begin
        unique case (job_r)
          J_NEW: begin
            en_new_r <= esat;
            vec_r    <= cur_r;
            ax_r     <= '0;
            eacc_r   <= '0;
            job_r    <= J_OLD;
          end
          J_OLD: en_old_r <= esat;
          default: begin
            tot_r <= tot_sat;
            p_r   <= p_r + CW'(1);
          end
        endcase
      end
      S_DIFF: begin
        neg_r <= en_new_r < en_old_r;
        mag_r <= (en_new_r < en_old_r) ? (en_old_r - en_new_r) : (en_new_r - en_old_r);
      end
      S_X2: xhi_r <= {prod_r[47:0], 8'b0};
      S_X3: x_r   <= 57'(xhi_r) + 57'(prod_r[63:16]);
      S_EXP1: if (x_big) e_r <= '0;
      S_EXP2: begin
        if (q_big) e_r <= '0;
        i_r <= i_sel;
        q_r <= prod_r[36:32];
      end
      S_EXP3: e_r <= m_val >> q_r;
      S_CMP2: rb_r <= prod_r[31:0];
      S_COMMIT: begin
        cur_r <= nw_r;
        acc_r <= 1'b1;
      end
      S_SCAN_GO: begin
        p_r   <= '0;
        tot_r <= '0;
      end
      S_SCAN_LAT: begin
        vec_r  <= rd_vec;
        ax_r   <= '0;
        eacc_r <= '0;
        job_r  <= J_SCAN;
      end
      default: ;
    endcase
  end

  // ---------------- result word ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      energy_total_r <= '0;
    end else if (state_r == S_FIN && fin_go) begin
      out_valid_r    <= 1'b1;
      energy_total_r <= tot_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && fin_go) begin
      out_accepted_r <= acc_r;
      out_oor_r      <= oor_r;
      out_x_r        <= 8'(signed'(cur_r[0]));
      out_y_r        <= 8'(signed'(cur_r[1]));
      out_z_r        <= 8'(signed'(cur_r[2]));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_out_of_range = out_oor_r;
  assign out_result_x     = out_x_r;
  assign out_result_y     = out_y_r;
  assign out_result_z     = out_z_r;
  assign out_total_energy = energy_total_r;

  // ---------------- checks ----------------
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while sequencer busy");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_WRAP))
    else $error("accepted word did not start the sequencer");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> (state_r == S_FIN && out_valid_r))
    else $error("result overwritten while held");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_out_of_range))
    else $error("move both taken and out of range");

  a_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EN_SQ || state_r == S_EN_MUL) |-> (32'(ax_r) < DIMENSIONS))
    else $error("energy axis counter past last axis");

endmodule

// ===== sim/tb_metropolis_momentum_state_update.sv =====
`timescale 1ns / 100ps
// self-checking testbench for metropolis_momentum_state_update: fills the particle store, then
// runs directed and random load/step words under several register settings with random stalls
// depends on mmsu_pkg and the block's rtl only
module tb_metropolis_momentum_state_update;
  import mmsu_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef logic [2:0][7:0] mom_t;

  typedef struct packed {
    logic        accepted;
    logic        out_of_range;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [47:0] energy;
  } outcome_t;

  class energy_book;
    mom_t        slots[256];
    logic [63:0] energy_sum;
    logic [1:0]  stat_mode;
    logic [8:0]  used;
    logic [31:0] wgt[3];
    logic [23:0] beta;
    int unsigned pow_tbl[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    outcome_t    expected_q[$];
    int          errors;

    function new();
      for (int p = 0; p < 256; p++) slots[p] = '0;
      energy_sum = 0;
      stat_mode  = MODE_RESET;
      used       = COUNT_RESET;
      for (int d = 0; d < 3; d++) wgt[d] = WEIGHT_RESET;
      beta   = BETA_RESET;
      errors = 0;
    endfunction

    function void set_reg(input mmsu_cfg_t r, input logic [31:0] v);
      case (r)
        CFG_MODE:     stat_mode = v[1:0];
        CFG_COUNT:    used = v[8:0];
        CFG_WEIGHT_X: wgt[0] = v;
        CFG_WEIGHT_Y: wgt[1] = v;
        CFG_WEIGHT_Z: wgt[2] = v;
        CFG_BETA:     beta = v[23:0];
        default: ;
      endcase
    endfunction

    function int in_use();
      return (used > 256) ? 256 : int'(used);
    endfunction

    function logic [63:0] particle_energy(input mom_t m);
      logic [63:0] e;
      longint      n;
      e = 0;
      for (int d = 0; d < 3; d++) begin
        n = longint'($signed(m[d]));
        if (n < 0) n = -n;
        e = e + 64'(wgt[d]) * 64'(n * n);
        if (e > 64'(ENERGY_MAX)) e = 64'(ENERGY_MAX);
      end
      return e;
    endfunction

    function logic [63:0] decay(input logic [63:0] x);
      logic [63:0] y;
      logic [63:0] q;
      int unsigned f, i, t, m;
      if (x >= (64'd32 << 16)) return 0;
      y = (x * 64'd94548) >> 16;
      q = y >> 16;
      if (q >= 17) return 0;
      f = int'(y[15:0]);
      i = f >> 12;
      t = f & 32'hFFF;
      m = pow_tbl[i] - (((pow_tbl[i] - pow_tbl[i + 1]) * t) >> 12);
      return 64'(m >> q);
    endfunction

    function void note_word(input logic act, input logic [7:0] idx, input logic [7:0] lx,
                            input logic [7:0] ly, input logic [7:0] lz, input logic kind,
                            input logic up, input logic [1:0] axis, input logic [15:0] r);
      mom_t        cur, nw;
      logic        acc, oor, blocked;
      int          v, n;
      logic [63:0] a, b, nn, no, mag, x, e;
      longint      de;
      outcome_t    o;
      acc = 0;
      oor = 0;
      cur = slots[idx];
      n = in_use();
      if (act == ACT_LOAD) begin
        slots[idx] = {lz, ly, lx};
      end else if (axis < 3) begin
        v = int'($signed(cur[axis]));
        if (kind == MOVE_STEP) v = up ? v + 1 : v - 1;
        else v = -v;
        if (v < -128 || v > 127) begin
          oor = 1;
        end else begin
          nw = cur;
          nw[axis] = v[7:0];
          a = 1;
          b = 1;
          blocked = 0;
          if (stat_mode == MODE_FERMION) begin
            for (int p = 0; p < n; p++)
              if (p != int'(idx) && slots[p] == nw) blocked = 1;
          end else if (stat_mode == MODE_BOSON) begin
            nn = 0;
            no = 0;
            for (int p = 0; p < n; p++) begin
              if (slots[p] == nw) nn++;
              if (slots[p] == cur) no++;
            end
            a = nn + 1;
            b = no;
          end
          if (!blocked) begin
            de = longint'(particle_energy(nw)) - longint'(particle_energy(cur));
            mag = (de < 0) ? 64'(-de) : 64'(de);
            x = ((64'(beta) * (mag >> 24)) << 8) + ((64'(beta) * (mag & 64'hFFFFFF)) >> 16);
            e = decay(x);
            if (de >= 0) acc = (e * a) > (64'(r) * b);
            else acc = (a << 32) > (64'(r) * b * e);
            if (acc) slots[idx] = nw;
          end
        end
      end
      energy_sum = 0;
      for (int p = 0; p < n; p++) begin
        energy_sum = energy_sum + particle_energy(slots[p]);
        if (energy_sum > 64'(ENERGY_MAX)) energy_sum = 64'(ENERGY_MAX);
      end
      o.accepted     = acc;
      o.out_of_range = oor;
      o.x            = slots[idx][0];
      o.y            = slots[idx][1];
      o.z            = slots[idx][2];
      o.energy       = energy_sum[47:0];
      expected_q.push_back(o);
    endfunction

    function void check_word(input outcome_t got);
      outcome_t w;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (got.accepted !== w.accepted) begin
        $error("accepted: expected %0d actual %0d", w.accepted, got.accepted);
        errors++;
      end
      if (got.out_of_range !== w.out_of_range) begin
        $error("out_of_range: expected %0d actual %0d", w.out_of_range, got.out_of_range);
        errors++;
      end
      if (got.x !== w.x) begin
        $error("result_x: expected %0d actual %0d", $signed(w.x), $signed(got.x));
        errors++;
      end
      if (got.y !== w.y) begin
        $error("result_y: expected %0d actual %0d", $signed(w.y), $signed(got.y));
        errors++;
      end
      if (got.z !== w.z) begin
        $error("result_z: expected %0d actual %0d", $signed(w.z), $signed(got.z));
        errors++;
      end
      if (got.energy !== w.energy) begin
        $error("total_energy: expected %0h actual %0h", w.energy, got.energy);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [7:0]        in_particle_index;
  logic signed [7:0] in_load_x;
  logic signed [7:0] in_load_y;
  logic signed [7:0] in_load_z;
  logic              in_move_kind;
  logic              in_step_up;
  logic [1:0]        in_move_axis;
  logic [15:0]       in_accept_random;
  logic              out_valid;
  logic              out_stall;
  logic              out_accepted;
  logic              out_out_of_range;
  logic signed [7:0] out_result_x;
  logic signed [7:0] out_result_y;
  logic signed [7:0] out_result_z;
  logic [47:0]       out_total_energy;
  logic              cfg_write_en;
  logic [2:0]        cfg_index;
  logic [31:0]       cfg_data;

  energy_book  book = new();
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned cycles;

  metropolis_momentum_state_update u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_particle_index (in_particle_index),
    .in_load_x         (in_load_x),
    .in_load_y         (in_load_y),
    .in_load_z         (in_load_z),
    .in_move_kind      (in_move_kind),
    .in_step_up        (in_step_up),
    .in_move_axis      (in_move_axis),
    .in_accept_random  (in_accept_random),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_out_of_range  (out_out_of_range),
    .out_result_x      (out_result_x),
    .out_result_y      (out_result_y),
    .out_result_z      (out_result_z),
    .out_total_energy  (out_total_energy),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // accepted words on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      book.note_word(in_action, in_particle_index, in_load_x, in_load_y, in_load_z,
                     in_move_kind, in_step_up, in_move_axis, in_accept_random);
    if (rst_n && out_valid && !out_stall)
      book.check_word({out_accepted, out_out_of_range, out_result_x, out_result_y,
                       out_result_z, out_total_energy});
  end

  task automatic send_word(input logic act, input logic [7:0] idx, input logic [7:0] lx,
                           input logic [7:0] ly, input logic [7:0] lz, input logic kind,
                           input logic up, input logic [1:0] axis, input logic [15:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_particle_index <= idx;
    in_load_x         <= lx;
    in_load_y         <= ly;
    in_load_z         <= lz;
    in_move_kind      <= kind;
    in_step_up        <= up;
    in_move_axis      <= axis;
    in_accept_random  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] vals[6]);
    for (int k = 0; k < 6; k++) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= 3'(k);
      cfg_data     <= vals[k];
      book.set_reg(mmsu_cfg_t'(k), vals[k]);
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_index(input int lim);
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(lim - 1));
  endfunction

  function automatic logic [7:0] pick_coord();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(6) - 3);
  endfunction

  initial begin
    logic [31:0] regs[6];
    int          lim, words;
    cycles            = 0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = ACT_LOAD;
    in_particle_index = '0;
    in_load_x         = '0;
    in_load_y         = '0;
    in_load_z         = '0;
    in_move_kind      = 1'b0;
    in_step_up        = 1'b0;
    in_move_axis      = '0;
    in_accept_random  = '0;
    out_stall         = 1'b0;
    cfg_write_en      = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    send_idle_pct     = 14;
    recv_idle_pct     = 79;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every slot, slot 0 first so the rescan never sees an empty slot
    send_word(ACT_LOAD, 8'd0, 8'h80, 8'h7F, 8'h00, 1'b0, 1'b0, 2'd0, 16'd0);
    send_word(ACT_LOAD, 8'd1, 8'h7F, 8'h80, 8'hFF, 1'b0, 1'b0, 2'd0, 16'd0);
    for (int p = 2; p < 256; p++)
      send_word(ACT_LOAD, 8'(p), pick_coord(), pick_coord(), pick_coord(), 1'b0, 1'b0,
                2'd0, 16'd0);

    // range exits, bad axis, both move kinds, extreme random fractions
    send_word(MOVE_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 2'd0, 16'd0);
    send_word(MOVE_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 2'd0, 16'd0);
    send_word(MOVE_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 2'd1, 16'd0);
    send_word(MOVE_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 2'd3, 16'd0);
    send_word(MOVE_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 2'd2, 16'd0);
    send_word(MOVE_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 2'd2, 16'hFFFF);
    send_word(MOVE_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 2'd1, 16'd0);
    send_word(MOVE_STEP, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 2'd0, 16'd0);
    send_word(MOVE_STEP, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 2'd0, 16'hFFFF);
    send_word(MOVE_STEP, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 2'd2, 16'h8000);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      if (ph == 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 14;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      regs[0] = 32'(ph % 4);
      regs[1] = (ph == 4) ? 32'd256 : (ph == 5) ? 32'd300 : 32'($urandom_range(2, 12));
      for (int d = 2; d < 5; d++)
        regs[d] = (ph == 1) ? 32'd0 : (ph == 2) ? 32'hFFFF_FFFF :
                  (32'($urandom_range(4)) << 16) + 32'($urandom_range(65535));
      regs[5] = (ph == 3) ? 32'd0 : (ph == 6) ? 32'hFF_FFFF : 32'($urandom_range(4 << 16));
      write_regs(regs);
      lim   = (regs[1] > 256) ? 256 : int'(regs[1]);
      words = (lim == 256) ? 12 : 180;
      for (int k = 0; k < words; k++) begin
        if ($urandom_range(99) < 15)
          send_word(ACT_LOAD, pick_index(lim), pick_coord(), pick_coord(), pick_coord(),
                    1'($urandom), 1'($urandom), 2'($urandom), 16'($urandom));
        else
          send_word(MOVE_STEP, pick_index(lim), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom),
                    ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
                    16'($urandom));
      end
    end

    drain();
    if (book.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
